// File: rtl/rspd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Remote serial packet deframer package
// Shared types, character codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package rspd_pkg;

   localparam int MAX_BODY = 1024;
   localparam int CNT_W    = $clog2(MAX_BODY + 1);
   localparam int LEN_W    = 11;

   localparam logic [7:0] CH_START = 8'h24;
   localparam logic [7:0] CH_END   = 8'h23;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_BODY = 2'd1,
      PH_HI   = 2'd2,
      PH_LO   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_BYTE = 2'd0,
      EV_GOOD = 2'd1,
      EV_BAD  = 2'd2,
      EV_ERR  = 2'd3
   } event_type;

   typedef struct packed {
      logic             valid;
      event_type        event_res;
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] body_length;
   } rsp_word_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok    = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage
`default_nettype wire

// File: rtl/rspd_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Receive channel
// Valid/ready channel that carries one received link character per word.
// ----------------------------------------------------------------------------
interface rspd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: rtl/rspd_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel that carries one deframer event per word.
// ----------------------------------------------------------------------------
interface rspd_rsp_if
   import rspd_pkg::*;
   ;
   logic             valid;
   logic             ready;
   event_type        event_res;
   logic [7:0]       data_byte;
   logic [LEN_W-1:0] body_length;

   modport source (output valid, output event_res, output data_byte, output body_length,
                   input ready);
   modport sink   (input valid, input event_res, input data_byte, input body_length,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/rspd_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer input stage
// Registers one received character and holds it until the decoder takes it.
// ----------------------------------------------------------------------------
module rspd_in_stage (
   input  wire logic   clock,
   input  wire logic   reset,
   rspd_req_if.sink    req_ch,
   input  wire logic   take,
   output logic        item_valid,
   output logic [7:0]  item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       load;

   assign req_ch.ready = !valid_ff || take;
   assign load         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_ch.rx_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule
`default_nettype wire

// File: rtl/rspd_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer decoder
// Packet phase, running checksum and body count; one character per take.
// ----------------------------------------------------------------------------
module rspd_decode
   import rspd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   take,
   input  wire logic [7:0] rx_byte,
   output rsp_word_type result
);

   phase_type        phase_ff, phase_in;
   logic [7:0]       sum_ff, sum_in;
   logic [3:0]       nibble_ff, nibble_in;
   logic [CNT_W-1:0] count_ff, count_in;
   hex_type          hex;

   assign hex = hex_decode(rx_byte);

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      nibble_in = nibble_ff;
      count_in  = count_ff;
      result    = '{valid: 1'b0, event_res: EV_BYTE, data_byte: 8'd0,
                    body_length: '0};
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == CH_START) begin
               phase_in = PH_BODY;
               sum_in   = 8'd0;
               count_in = '0;
            end else begin
               result.valid     = 1'b1;
               result.event_res = EV_ERR;
            end
         end
         PH_BODY: begin
            if (rx_byte == CH_END) begin
               phase_in = PH_HI;
            end else if (count_ff >= CNT_W'(MAX_BODY)) begin
               phase_in         = PH_HUNT;
               result.valid     = 1'b1;
               result.event_res = EV_ERR;
            end else begin
               sum_in           = sum_ff + rx_byte;
               count_in         = count_ff + 1'b1;
               result.valid     = 1'b1;
               result.event_res = EV_BYTE;
               result.data_byte = rx_byte;
            end
         end
         PH_HI: begin
            if (hex.ok) begin
               nibble_in = hex.value;
               phase_in  = PH_LO;
            end else begin
               phase_in         = PH_HUNT;
               result.valid     = 1'b1;
               result.event_res = EV_ERR;
            end
         end
         PH_LO: begin
            phase_in     = PH_HUNT;
            result.valid = 1'b1;
            if (!hex.ok) begin
               result.event_res = EV_ERR;
            end else if ({nibble_ff, hex.value} == sum_ff) begin
               result.event_res   = EV_GOOD;
               result.body_length = LEN_W'(count_ff);
            end else begin
               result.event_res = EV_BAD;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         sum_ff    <= 8'd0;
         nibble_ff <= 4'd0;
         count_ff  <= '0;
      end else if (take) begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         nibble_ff <= nibble_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/rspd_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer output stage
// Result register; holds an event word until the receiver takes it.
// ----------------------------------------------------------------------------
module rspd_out_stage
   import rspd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   rspd_rsp_if.source  rsp_ch,
   input  wire logic   take,
   input  wire rsp_word_type result,
   output logic        out_free
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign out_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = result.valid;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && result.valid) begin
         word_ff <= result;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.event_res   = word_ff.event_res;
   assign rsp_ch.data_byte   = word_ff.data_byte;
   assign rsp_ch.body_length = word_ff.body_length;

endmodule
`default_nettype wire

// File: rtl/remote_serial_packet_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Remote serial packet deframer
// Deframes $body#hh packets from a received character stream.
//
// req_ch carries one received character per word; rsp_ch carries events:
// body byte, packet good (with body length), checksum bad, framing error.
// The '$' start, the '#' end and a valid first checksum digit give no event.
// An event word is registered in the input register at the accepting edge
// and then in the result register, through the decoder, when the decoder
// takes the character.
// Throughput is one word per cycle unless rsp_ch stalls; the decoder phase,
// checksum and body count update on each take; a word may follow every cycle.
// When rsp_ch stalls with a word held, the decoder stops and the input
// register holds one more character; req_ch ready then stays low until the
// receiver takes the held word, also for characters that give no event.
// Reset clears both registers' valid flags and returns the decoder to
// hunting for '$' with a zero checksum and count.
// ----------------------------------------------------------------------------
module remote_serial_packet_deframer
   import rspd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rspd_req_if.sink   req_ch,
   rspd_rsp_if.source rsp_ch
);

   logic         item_valid;
   logic [7:0]   item_byte;
   logic         out_free;
   logic         take;
   rsp_word_type result;

   assign take = item_valid && out_free;

   rspd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .take       (take),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   rspd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (item_byte),
      .result  (result)
   );

   rspd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .rsp_ch   (rsp_ch),
      .take     (take),
      .result   (result),
      .out_free (out_free)
   );

endmodule
`default_nettype wire
